/* design/sob_pkg.sv */
`default_nettype none
package sob_pkg;

    localparam int QUO_W      = 32;
    localparam int NUM_W      = 52;
    localparam int DEN_W      = 16;
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = QUO_W / DIV_STEP;
    localparam int LO_W       = 37;

    localparam logic signed [31:0] T_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] T_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        CFG_CENTER_XY = 3'd0,
        CFG_CENTER_Z  = 3'd1,
        CFG_HALF_XY   = 3'd2,
        CFG_HALF_Z    = 3'd3,
        CFG_ROW0      = 3'd4,
        CFG_ROW1      = 3'd5,
        CFG_ROW2      = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        logic [DEN_W-1:0] den;
        logic             neg;
        logic             ovf;
    } t_div;

    typedef struct packed {
        logic signed [2:0][LO_W-1:0] lo;
        logic signed [2:0][15:0]     ld;
        logic [2:0]                  zero;
        logic [30:0]                 len;
        logic                        miss;
    } t_side;

    function automatic logic signed [31:0] sat38(input logic signed [37:0] v);
        logic signed [31:0] r;
        if (v > 38'(T_MAX)) begin
            r = T_MAX;
        end else if (v < 38'(T_MIN)) begin
            r = T_MIN;
        end else begin
            r = 32'(v);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* design/sob_div.sv */
`default_nettype none
module sob_div import sob_pkg::*; (
    input  wire logic               i_clk,
    input  wire t_div               i_req,
    output logic signed [QUO_W-1:0] o_t
);

    t_div r_st [DIV_STAGES];
    t_div n_st [DIV_STAGES];
    t_div w_last;

    always_comb begin
        t_div             cur;
        int               sh;
        logic [NUM_W-1:0] dsh;
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (s == 0) begin
                cur = i_req;
            end else begin
                cur = r_st[s-1];
            end
            for (int b = 0; b < DIV_STEP; b++) begin
                sh  = QUO_W - 1 - (s * DIV_STEP + b);
                dsh = NUM_W'(cur.den) << sh;
                if (cur.rem >= dsh) begin
                    cur.rem     = cur.rem - dsh;
                    cur.quo[sh] = 1'b1;
                end
            end
            n_st[s] = cur;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < DIV_STAGES; s++) begin
            r_st[s] <= n_st[s];
        end
    end

    assign w_last = r_st[DIV_STAGES-1];

    always_comb begin
        if (w_last.ovf) begin
            o_t = w_last.neg ? T_MIN : T_MAX;
        end else if (!w_last.neg) begin
            o_t = w_last.quo[QUO_W-1] ? T_MAX : $signed(w_last.quo);
        end else if (w_last.quo > {1'b1, {(QUO_W-1){1'b0}}}) begin
            o_t = T_MIN;
        end else begin
            o_t = $signed(-w_last.quo);
        end
    end

endmodule
`default_nettype wire

/* design/segment_oriented_box_clip.sv */
// Channel   Direction  Handshake            Payload
// request   in         start & !busy        i_origin_*, i_dir_*, i_seg_length
// result    out        o_strobe, one cycle  o_hit, o_entry_*, o_local_dir_*, o_clipped_length
// config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// One request per cycle; busy is always low.
// The result path is registered in four frame-change and setup stages,
// eight radix-16 stages of the six slab dividers and four merge stages.
// Reset clears the valid chain and loads the identity frame; data registers hold.
// The receiver takes every strobe, so the pipeline never stalls.
`default_nettype none
module segment_oriented_box_clip import sob_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] i_origin_x,
    input  wire logic signed [31:0] i_origin_y,
    input  wire logic signed [31:0] i_origin_z,
    input  wire logic signed [15:0] i_dir_x,
    input  wire logic signed [15:0] i_dir_y,
    input  wire logic signed [15:0] i_dir_z,
    input  wire logic [30:0]        i_seg_length,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [63:0]        i_cfg_data,
    output logic                    o_strobe,
    output logic                    o_hit,
    output logic signed [31:0]      o_entry_x,
    output logic signed [31:0]      o_entry_y,
    output logic signed [31:0]      o_entry_z,
    output logic signed [15:0]      o_local_dir_x,
    output logic signed [15:0]      o_local_dir_y,
    output logic signed [15:0]      o_local_dir_z,
    output logic signed [31:0]      o_clipped_length
);

    localparam int LAT = 8 + DIV_STAGES;

    logic [63:0] r_cen_xy;
    logic [31:0] r_cen_z;
    logic [63:0] r_half_xy;
    logic [30:0] r_half_z;
    logic [47:0] r_row [3];

    logic [LAT-1:0] r_vld;

    logic signed [32:0] r1_dlt [3];
    logic signed [15:0] r1_dir [3];
    logic [30:0]        r1_len;

    logic signed [48:0] r2_po [3][3];
    logic signed [31:0] r2_pd [3][3];
    logic [30:0]        r2_len;

    logic signed [LO_W-1:0] r3_lo [3];
    logic signed [15:0]     r3_ld [3];
    logic [30:0]            r3_len;

    t_div  r4_dv [6];
    t_div  n4_dv [6];
    t_side r4_side;
    t_side n4_side;

    t_side r_dly [DIV_STAGES];
    logic signed [31:0] w_t [6];

    logic signed [31:0] r5_tn [3];
    logic signed [31:0] r5_tf [3];
    t_side              r5_side;

    logic signed [31:0] r6_near;
    logic signed [31:0] r6_far;
    t_side              r6_side;

    logic signed [47:0] r7_prod [3];
    logic signed [32:0] r7_clip;
    logic               r7_adv;
    t_side              r7_side;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cen_xy  <= '0;
            r_cen_z   <= '0;
            r_half_xy <= '0;
            r_half_z  <= '0;
            r_row[0]  <= 48'h0000_0000_4000;
            r_row[1]  <= 48'h0000_4000_0000;
            r_row[2]  <= 48'h4000_0000_0000;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_CENTER_XY: r_cen_xy  <= i_cfg_data;
                CFG_CENTER_Z:  r_cen_z   <= i_cfg_data[31:0];
                CFG_HALF_XY:   r_half_xy <= i_cfg_data;
                CFG_HALF_Z:    r_half_z  <= i_cfg_data[30:0];
                CFG_ROW0:      r_row[0]  <= i_cfg_data[47:0];
                CFG_ROW1:      r_row[1]  <= i_cfg_data[47:0];
                CFG_ROW2:      r_row[2]  <= i_cfg_data[47:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start};
        end
    end

    // frame change: delta, products, sums
    always_ff @(posedge i_clk) begin
        r1_dlt[0] <= 33'(i_origin_x) - 33'($signed(r_cen_xy[31:0]));
        r1_dlt[1] <= 33'(i_origin_y) - 33'($signed(r_cen_xy[63:32]));
        r1_dlt[2] <= 33'(i_origin_z) - 33'($signed(r_cen_z));
        r1_dir[0] <= i_dir_x;
        r1_dir[1] <= i_dir_y;
        r1_dir[2] <= i_dir_z;
        r1_len    <= i_seg_length;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r2_po[i][j] <= $signed(r_row[i][16*j +: 16]) * r1_dlt[j];
                r2_pd[i][j] <= $signed(r_row[i][16*j +: 16]) * r1_dir[j];
            end
        end
        r2_len <= r1_len;
    end

    always_ff @(posedge i_clk) begin
        logic signed [50:0] ao;
        logic signed [33:0] ad;
        logic signed [19:0] adf;
        for (int i = 0; i < 3; i++) begin
            ao = 51'(r2_po[i][0]) + 51'(r2_po[i][1]) + 51'(r2_po[i][2]);
            ad = 34'(r2_pd[i][0]) + 34'(r2_pd[i][1]) + 34'(r2_pd[i][2]);
            adf = 20'(ad >>> 14);
            r3_lo[i] <= LO_W'(ao >>> 14);
            if (adf > 20'sd32767) begin
                r3_ld[i] <= 16'sh7fff;
            end else if (adf < -20'sd32768) begin
                r3_ld[i] <= 16'sh8000;
            end else begin
                r3_ld[i] <= 16'(adf);
            end
        end
        r3_len <= r2_len;
    end

    // slab setup: early rejects, divider operands
    always_comb begin
        logic signed [32:0] h;
        logic signed [33:0] nh;
        logic signed [37:0] n;
        logic [37:0]        mag;
        logic [15:0]        den;
        n4_side.len  = r3_len;
        n4_side.miss = 1'b0;
        for (int i = 0; i < 3; i++) begin
            case (i)
                0:       h = $signed({1'b0, r_half_xy[31:0]});
                1:       h = $signed({1'b0, r_half_xy[63:32]});
                default: h = $signed({2'b0, r_half_z});
            endcase
            nh = -(34'(h));
            n4_side.lo[i]   = r3_lo[i];
            n4_side.ld[i]   = r3_ld[i];
            n4_side.zero[i] = (r3_ld[i] == 16'sd0);
            if (r3_ld[i] >= 16'sd0) begin
                if (r3_lo[i] >= h) begin
                    n4_side.miss = 1'b1;
                end
            end else if (r3_lo[i] <= nh) begin
                n4_side.miss = 1'b1;
            end
            if (n4_side.zero[i] && r3_lo[i] <= nh) begin
                n4_side.miss = 1'b1;
            end
            den = r3_ld[i][15] ? 16'(-17'(r3_ld[i])) : 16'(r3_ld[i]);
            for (int k = 0; k < 2; k++) begin
                if (k == 0) begin
                    n = 38'(h) - 38'(r3_lo[i]);
                end else begin
                    n = 38'(nh) - 38'(r3_lo[i]);
                end
                mag = n[37] ? 38'(-n) : 38'(n);
                n4_dv[2*i+k].rem = {mag, 14'b0};
                n4_dv[2*i+k].quo = '0;
                n4_dv[2*i+k].den = den;
                n4_dv[2*i+k].neg = n[37] ^ r3_ld[i][15];
                n4_dv[2*i+k].ovf = ({mag, 14'b0} >> QUO_W) >= NUM_W'(den);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 6; k++) begin
            r4_dv[k] <= n4_dv[k];
        end
        r4_side <= n4_side;
    end

    for (genvar k = 0; k < 6; k++) begin : g_div
        sob_div u_div (
            .i_clk (i_clk),
            .i_req (r4_dv[k]),
            .o_t   (w_t[k])
        );
    end

    always_ff @(posedge i_clk) begin
        r_dly[0] <= r4_side;
        for (int s = 1; s < DIV_STAGES; s++) begin
            r_dly[s] <= r_dly[s-1];
        end
    end

    // merge: slab order, interval, entry and clipped length
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (r_dly[DIV_STAGES-1].zero[i]) begin
                r5_tn[i] <= T_MIN;
                r5_tf[i] <= T_MAX;
            end else if (w_t[2*i+1] <= w_t[2*i]) begin
                r5_tn[i] <= w_t[2*i+1];
                r5_tf[i] <= w_t[2*i];
            end else begin
                r5_tn[i] <= w_t[2*i];
                r5_tf[i] <= w_t[2*i+1];
            end
        end
        r5_side <= r_dly[DIV_STAGES-1];
    end

    always_ff @(posedge i_clk) begin
        logic signed [31:0] nr;
        logic signed [31:0] fr;
        t_side              sd;
        nr = r5_tn[0];
        fr = r5_tf[0];
        for (int i = 1; i < 3; i++) begin
            if (r5_tn[i] > nr) begin
                nr = r5_tn[i];
            end
            if (r5_tf[i] < fr) begin
                fr = r5_tf[i];
            end
        end
        sd      = r5_side;
        sd.miss = r5_side.miss || (nr > fr) || (fr < 32'sd0)
                  || (33'(nr) > $signed({2'b0, r5_side.len}));
        r6_near <= nr;
        r6_far  <= fr;
        r6_side <= sd;
    end

    always_ff @(posedge i_clk) begin
        logic signed [32:0] fc;
        logic signed [32:0] st;
        for (int i = 0; i < 3; i++) begin
            r7_prod[i] <= $signed(r6_side.ld[i]) * r6_near;
        end
        fc = ($signed({2'b0, r6_side.len}) < 33'(r6_far)) ? $signed({2'b0, r6_side.len})
                                                             : 33'(r6_far);
        st = (r6_near >= 32'sd0) ? 33'(r6_near) : 33'sd0;
        r7_clip <= fc - st;
        r7_adv  <= (r6_near >= 32'sd0);
        r7_side <= r6_side;
    end

    always_ff @(posedge i_clk) begin
        logic signed [37:0] e [3];
        for (int i = 0; i < 3; i++) begin
            e[i] = 38'($signed(r7_side.lo[i]));
            if (r7_adv) begin
                e[i] = e[i] + 38'(r7_prod[i] >>> 14);
            end
        end
        o_hit <= !r7_side.miss;
        if (r7_side.miss) begin
            o_entry_x        <= '0;
            o_entry_y        <= '0;
            o_entry_z        <= '0;
            o_local_dir_x    <= '0;
            o_local_dir_y    <= '0;
            o_local_dir_z    <= '0;
            o_clipped_length <= '0;
        end else begin
            o_entry_x        <= sat38(e[0]);
            o_entry_y        <= sat38(e[1]);
            o_entry_z        <= sat38(e[2]);
            o_local_dir_x    <= r7_side.ld[0];
            o_local_dir_y    <= r7_side.ld[1];
            o_local_dir_z    <= r7_side.ld[2];
            o_clipped_length <= sat38(38'(r7_clip));
        end
    end

    assign o_strobe = r_vld[LAT-1];

endmodule
`default_nettype wire

/* dv/segment_oriented_box_clip_chk.sv */
`timescale 1ns / 100ps
module segment_oriented_box_clip_chk import sob_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire logic signed [31:0] i_origin_x,
    input  wire logic signed [31:0] i_origin_y,
    input  wire logic signed [31:0] i_origin_z,
    input  wire logic signed [15:0] i_dir_x,
    input  wire logic signed [15:0] i_dir_y,
    input  wire logic signed [15:0] i_dir_z,
    input  wire logic [30:0]        i_seg_length,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [63:0]        i_cfg_data,
    input  wire logic               o_strobe,
    input  wire logic               o_hit,
    input  wire logic signed [31:0] o_entry_x,
    input  wire logic signed [31:0] o_entry_y,
    input  wire logic signed [31:0] o_entry_z,
    input  wire logic signed [15:0] o_local_dir_x,
    input  wire logic signed [15:0] o_local_dir_y,
    input  wire logic signed [15:0] o_local_dir_z,
    input  wire logic signed [31:0] o_clipped_length,
    output int                      o_fail_cnt,
    output int                      o_pending
);

    typedef struct packed {
        logic               hit;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
        logic signed [31:0] ez;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic signed [15:0] dz;
        logic signed [31:0] clen;
    } t_clip;

    localparam longint TIME_MAX = 64'sd2147483647;
    localparam longint TIME_MIN = -64'sd2147483648;

    logic [63:0] box_center_xy;
    logic [31:0] box_center_z;
    logic [63:0] half_size_xy;
    logic [30:0] half_size_z;
    logic [47:0] axis_row [3];

    t_clip clip_q [$];

    function automatic longint clamp(input longint v, input longint lo_v, input longint hi_v);
        return (v < lo_v) ? lo_v : ((v > hi_v) ? hi_v : v);
    endfunction

    function automatic t_clip clip_segment(input logic [31:0] ox, input logic [31:0] oy,
                                           input logic [31:0] oz, input logic [15:0] dxi,
                                           input logic [15:0] dyi, input logic [15:0] dzi,
                                           input logic [30:0] seg_len);
        longint org [3];
        longint dvec [3];
        longint cen [3];
        longint half [3];
        longint lo [3];
        longint ld [3];
        longint len, nearv, farv, t_start, ao, ad, a, t0, t1, tn, tf;
        bit     hit;
        t_clip  r;
        org[0]  = longint'($signed(ox));
        org[1]  = longint'($signed(oy));
        org[2]  = longint'($signed(oz));
        dvec[0] = longint'($signed(dxi));
        dvec[1] = longint'($signed(dyi));
        dvec[2] = longint'($signed(dzi));
        cen[0]  = longint'($signed(box_center_xy[31:0]));
        cen[1]  = longint'($signed(box_center_xy[63:32]));
        cen[2]  = longint'($signed(box_center_z));
        half[0] = longint'({32'd0, half_size_xy[31:0]});
        half[1] = longint'({32'd0, half_size_xy[63:32]});
        half[2] = longint'({33'd0, half_size_z});
        len     = longint'({33'd0, seg_len});
        nearv   = TIME_MIN;
        farv    = TIME_MAX;
        t_start = 0;
        hit     = 1'b1;
        r       = '0;
        for (int i = 0; i < 3; i++) begin
            ao = 0;
            ad = 0;
            for (int j = 0; j < 3; j++) begin
                a  = longint'($signed(axis_row[i][16*j +: 16]));
                ao += a * (org[j] - cen[j]);
                ad += a * dvec[j];
            end
            lo[i] = ao >>> 14;
            ld[i] = clamp(ad >>> 14, -32768, 32767);
        end
        for (int i = 0; i < 3; i++) begin
            if (hit) begin
                if (ld[i] >= 0) begin
                    if (lo[i] >= half[i]) hit = 1'b0;
                end else if (lo[i] <= -half[i]) begin
                    hit = 1'b0;
                end
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (hit) begin
                if (ld[i] == 0) begin
                    if (lo[i] <= -half[i] || lo[i] >= half[i]) hit = 1'b0;
                    tn = TIME_MIN;
                    tf = TIME_MAX;
                end else begin
                    t0 = clamp(((half[i] - lo[i]) * 16384) / ld[i], TIME_MIN, TIME_MAX);
                    t1 = clamp(((-half[i] - lo[i]) * 16384) / ld[i], TIME_MIN, TIME_MAX);
                    tn = (t1 <= t0) ? t1 : t0;
                    tf = (t1 <= t0) ? t0 : t1;
                end
                if (hit) begin
                    if (tn > nearv) nearv = tn;
                    if (tf < farv) farv = tf;
                    if (nearv > farv || farv < 0 || nearv > len) hit = 1'b0;
                end
            end
        end
        if (!hit) return r;
        if (nearv >= 0) begin
            for (int i = 0; i < 3; i++) lo[i] += (ld[i] * nearv) >>> 14;
            t_start = nearv;
        end
        if (len < farv) farv = len;
        r.hit  = 1'b1;
        r.ex   = 32'(clamp(lo[0], TIME_MIN, TIME_MAX));
        r.ey   = 32'(clamp(lo[1], TIME_MIN, TIME_MAX));
        r.ez   = 32'(clamp(lo[2], TIME_MIN, TIME_MAX));
        r.dx   = 16'(ld[0]);
        r.dy   = 16'(ld[1]);
        r.dz   = 16'(ld[2]);
        r.clen = 32'(clamp(farv - t_start, TIME_MIN, TIME_MAX));
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t clip %s: got %0h expected %0h", $time, what, got, want);
        o_fail_cnt++;
    endtask

    initial begin
        o_fail_cnt = 0;
        o_pending  = 0;
    end

    always @(posedge i_clk) begin
        t_clip got, want;
        if (!i_rst_n) begin
            box_center_xy <= '0;
            box_center_z  <= '0;
            half_size_xy  <= '0;
            half_size_z   <= '0;
            axis_row[0]   <= 48'h0000_0000_4000;
            axis_row[1]   <= 48'h0000_4000_0000;
            axis_row[2]   <= 48'h4000_0000_0000;
            clip_q.delete();
        end else begin
            if (o_strobe) begin
                got = {o_hit, o_entry_x, o_entry_y, o_entry_z, o_local_dir_x,
                       o_local_dir_y, o_local_dir_z, o_clipped_length};
                if (clip_q.size() == 0) begin
                    report_mismatch("unexpected result", got.hit, 0);
                end else begin
                    want = clip_q.pop_front();
                    if (got.hit !== want.hit) report_mismatch("hit", got.hit, want.hit);
                    if (got.ex !== want.ex) report_mismatch("entry_x", got.ex, want.ex);
                    if (got.ey !== want.ey) report_mismatch("entry_y", got.ey, want.ey);
                    if (got.ez !== want.ez) report_mismatch("entry_z", got.ez, want.ez);
                    if (got.dx !== want.dx) report_mismatch("local_dir_x", got.dx, want.dx);
                    if (got.dy !== want.dy) report_mismatch("local_dir_y", got.dy, want.dy);
                    if (got.dz !== want.dz) report_mismatch("local_dir_z", got.dz, want.dz);
                    if (got.clen !== want.clen)
                        report_mismatch("clipped_length", got.clen, want.clen);
                end
            end
            if (start && !busy) begin
                clip_q.push_back(clip_segment(i_origin_x, i_origin_y, i_origin_z, i_dir_x,
                                              i_dir_y, i_dir_z, i_seg_length));
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CENTER_XY: box_center_xy <= i_cfg_data;
                    CFG_CENTER_Z:  box_center_z  <= i_cfg_data[31:0];
                    CFG_HALF_XY:   half_size_xy  <= i_cfg_data;
                    CFG_HALF_Z:    half_size_z   <= i_cfg_data[30:0];
                    CFG_ROW0:      axis_row[0]   <= i_cfg_data[47:0];
                    CFG_ROW1:      axis_row[1]   <= i_cfg_data[47:0];
                    CFG_ROW2:      axis_row[2]   <= i_cfg_data[47:0];
                    default: ;
                endcase
            end
        end
        o_pending <= clip_q.size();
    end

endmodule

/* dv/segment_oriented_box_clip_tb.sv */
`timescale 1ns / 100ps
module segment_oriented_box_clip_tb import sob_pkg::*;;

    localparam int PHASE_ITEMS = 220;
    localparam int CALM_ITEMS  = 150;
    localparam int DRAIN_WAIT  = 24;
    localparam int STALL_LIMIT = 4000;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] i_origin_x, i_origin_y, i_origin_z;
    logic signed [15:0] i_dir_x, i_dir_y, i_dir_z;
    logic [30:0]        i_seg_length;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_idx;
    logic [63:0]        i_cfg_data;
    logic               o_strobe, o_hit;
    logic signed [31:0] o_entry_x, o_entry_y, o_entry_z;
    logic signed [15:0] o_local_dir_x, o_local_dir_y, o_local_dir_z;
    logic signed [31:0] o_clipped_length;
    int                 fail_cnt;
    int                 pending;
    int                 stall_cnt;

    logic signed [31:0] cur_cen [3];
    logic [31:0]        cur_half;

    segment_oriented_box_clip u_dut (.*);

    segment_oriented_box_clip_chk u_chk (
        .*,
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    // drive at a rising edge, return at the edge that takes the request
    task automatic send(input logic [31:0] ox, input logic [31:0] oy, input logic [31:0] oz,
                        input logic [15:0] dx, input logic [15:0] dy, input logic [15:0] dz,
                        input logic [30:0] len);
        bit ready;
        start        <= 1'b1;
        i_origin_x   <= ox;
        i_origin_y   <= oy;
        i_origin_z   <= oz;
        i_dir_x      <= dx;
        i_dir_y      <= dy;
        i_dir_z      <= dz;
        i_seg_length <= len;
        do begin
            @(negedge i_clk);
            ready = !busy;
            @(posedge i_clk);
        end while (!ready);
    endtask

    task automatic hold_idle(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_drain();
        hold_idle(1);
        wait (pending == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic load_frame(input logic [63:0] cxy, input logic [31:0] cz,
                              input logic [63:0] hxy, input logic [30:0] hz,
                              input logic [47:0] r0, input logic [47:0] r1,
                              input logic [47:0] r2);
        logic [63:0] vals [8];
        vals = '{cxy, {32'd0, cz}, hxy, {33'd0, hz}, {16'd0, r0}, {16'd0, r1}, {16'd0, r2},
                 {$urandom, $urandom}};
        for (int k = 0; k < 8; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= 3'(k);
            i_cfg_data <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        cur_cen[0] = cxy[31:0];
        cur_cen[1] = cxy[63:32];
        cur_cen[2] = cz;
        cur_half   = hxy[31:0];
    endtask

    function automatic logic [31:0] near_box(input int a);
        logic signed [31:0] off;
        off = $signed($urandom_range(0, 32'h000c_0000)) - 32'sh0006_0000;
        if ($urandom_range(0, 3) == 0) off = off + $signed(cur_half) - 32'sh0001_0000;
        return cur_cen[a] + off;
    endfunction

    function automatic logic [15:0] dir_part();
        case ($urandom_range(0, 5))
            0:       return 16'h0;
            1:       return 16'h4000;
            2:       return 16'hc000;
            3:       return 16'(($urandom_range(0, 32767)));
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    task automatic random_phase(input int n, input bit calm_tail);
        logic [31:0] ox, oy, oz;
        logic [30:0] len;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 4) == 0) begin
                ox  = $urandom;
                oy  = $urandom;
                oz  = $urandom;
                len = 31'($urandom);
                send(ox, oy, oz, 16'($urandom), 16'($urandom), 16'($urandom), len);
            end else begin
                ox  = near_box(0);
                oy  = near_box(1);
                oz  = near_box(2);
                len = ($urandom_range(0, 7) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 21));
                send(ox, oy, oz, dir_part(), dir_part(), dir_part(), len);
            end
            if (!(calm_tail && k >= n - CALM_ITEMS) && $urandom_range(0, 3) == 0)
                hold_idle($urandom_range(1, 9));
        end
    endtask

    initial begin
        i_clk        = 1'b0;
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_origin_x   <= '0;
        i_origin_y   <= '0;
        i_origin_z   <= '0;
        i_dir_x      <= '0;
        i_dir_y      <= '0;
        i_dir_z      <= '0;
        i_seg_length <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= '0;
        i_cfg_data   <= '0;
        cur_cen      = '{0, 0, 0};
        cur_half     = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset frame: zero half sizes
        send(32'h0, 32'h0, 32'h0, 16'h4000, 16'h0, 16'h0, 31'h100000);
        send(32'h0001_0000, 32'h0, 32'h0, 16'hc000, 16'h0, 16'h0, 31'h100000);
        random_phase(20, 1'b0);
        wait_drain();

        load_frame({32'h0001_0000, 32'hffff_0000}, 32'h0000_8000,
                   {32'h0004_0000, 32'h0004_0000}, 31'h0004_0000,
                   48'h0000_0000_4000, 48'h0000_4000_0000, 48'h4000_0000_0000);
        send(32'hffff_0000, 32'h0001_0000, 32'h0000_8000, 16'h0, 16'h0, 16'h0, 31'h0);
        send(32'hfff0_0000, 32'h0001_0000, 32'h0000_8000, 16'h4000, 16'h0, 16'h0,
             31'h7fff_ffff);
        send(32'hfff0_0000, 32'h0001_0000, 32'h0000_8000, 16'h4000, 16'h0, 16'h0, 31'h0);
        send(32'hfff0_0000, 32'h0001_0000, 32'h0000_8000, 16'hc000, 16'h0, 16'h0,
             31'h100000);
        send(32'h0003_0000, 32'h0005_0000, 32'h0000_8000, 16'h4000, 16'h0, 16'h0,
             31'h100000);
        send(32'h0003_0000, 32'h0001_0000, 32'h0000_8000, 16'h0, 16'h0, 16'h4000,
             31'h100000);
        send(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 16'h7fff, 16'h8000, 16'h7fff,
             31'h7fff_ffff);
        send(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 16'h8000, 16'h7fff, 16'h8000,
             31'h7fff_ffff);
        send(32'hffff_0000, 32'h0001_0000, 32'h0000_8000, 16'h7fff, 16'h7fff, 16'h7fff,
             31'h10);
        send(32'hffff_0000, 32'h0001_0000, 32'h0000_8000, 16'h8000, 16'h8000, 16'h8000,
             31'h7fff_ffff);
        send(32'h0003_0000, 32'h0001_0000, 32'h0000_8000, 16'h0, 16'h4000, 16'h0,
             31'h1);
        send(32'hfff8_0000, 32'hfff8_0000, 32'hfff8_0000, 16'h2d41, 16'h2d41, 16'h0,
             31'h0040_0000);
        random_phase(PHASE_ITEMS, 1'b0);
        wait_drain();

        // quarter turn about z
        load_frame({$urandom_range(0, 32'h000f_ffff), $urandom_range(0, 32'h000f_ffff)},
                   32'hfffe_0000, {32'h0002_0000, 32'h0008_0000}, 31'h0003_0000,
                   48'h0000_4000_0000, 48'h0000_0000_c000, 48'h4000_0000_0000);
        random_phase(PHASE_ITEMS, 1'b0);
        wait_drain();

        // eighth turn about z
        load_frame({32'h0, 32'h0010_0000}, 32'h0, {32'h0006_0000, 32'h0006_0000},
                   31'h0006_0000, 48'h0000_2d41_2d41, 48'h0000_2d41_d2bf,
                   48'h4000_0000_0000);
        random_phase(PHASE_ITEMS, 1'b0);
        wait_drain();

        load_frame({32'h7fff_ffff, 32'h8000_0000}, 32'h7fff_ffff,
                   {32'hffff_ffff, 32'hffff_ffff}, 31'h7fff_ffff,
                   48'h8000_8000_8000, 48'h7fff_7fff_7fff, 48'h8000_7fff_8000);
        random_phase(PHASE_ITEMS / 2, 1'b0);
        wait_drain();

        load_frame({$urandom, $urandom}, $urandom, {$urandom, $urandom}, 31'($urandom),
                   {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
        random_phase(PHASE_ITEMS / 2, 1'b0);
        wait_drain();

        load_frame({32'h0, 32'h0}, 32'h0, {32'h0010_0000, 32'h0010_0000}, 31'h0010_0000,
                   48'h0000_0000_4000, 48'h0000_4000_0000, 48'h4000_0000_0000);
        random_phase(PHASE_ITEMS, 1'b1);

        hold_idle(1);
        wait (pending == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
